// ===== hdl/victim_frame_selector_top_defines.svh =====
`ifndef VICTIM_FRAME_SELECTOR_TOP_DEFINES_SVH
`define VICTIM_FRAME_SELECTOR_TOP_DEFINES_SVH

// Same-cycle check: cons must hold whenever ante holds.
`define VFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define VFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vfs_pkg.sv =====
package vfs_pkg;

	localparam int FRAME_COUNT_DEF = 16;
	localparam int PAGE_BITS_DEF   = 16;
	localparam int STAMP_BITS_DEF  = 32;

	localparam int COIN_W  = 16;
	localparam int BASE_W  = 4;
	localparam int FRAME_W = 4;
	localparam int PAGE_W  = 16;
	localparam int STAMP_W = 32;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_USED_W  = FRAME_W + 1 + BASE_W + PAGE_W;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SELECT = 1'b1;

	localparam logic POL_RANDOM = 1'b0;
	localparam logic POL_LRU    = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t STAT_LOAD   = 2'd0;
	localparam status_t STAT_CHOSEN = 2'd1;
	localparam status_t STAT_OOM    = 2'd2;

endpackage

// ===== hdl/victim_frame_selector_top.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: frame, mapped, protected, base,
//                                   page, stamp, coin bits
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: victim, evicted, base, page
// cfg_*     in   cfg_we             cfg_data: policy (0 random, 1 LRU)
//
// A load goes from the idle state to the reply state; a select passes through the scan,
// drain, decide and reply states, the scan reading one frame per cycle through the
// table RAM's single read port into one shared stamp comparator.
// Input is taken only while the sequencer is idle; a finished result waits in the output
// register and the next item may be taken meanwhile. Reset selects LRU and clears the
// mapped and protected bits; a frame never loaded is free and its stamp decides nothing.
`include "victim_frame_selector_top_defines.svh"

module victim_frame_selector_top #(
	parameter int FRAME_COUNT = vfs_pkg::FRAME_COUNT_DEF,
	parameter int PAGE_BITS   = vfs_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS  = vfs_pkg::STAMP_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [3:0] frame, [4] mapped_in, [5] protected_in, [9:6] owner_base_in,
	// [25:10] owner_page_in, [57:26] stamp_in, [73:58] coin_bits, [79:74] zero
	input  logic [vfs_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] action
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [3:0] victim, [4] evicted, [8:5] evict_base, [24:9] evict_page, [31:25] zero
	output logic [vfs_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [1:0] status
	output vfs_pkg::status_t                   m_tuser
);

	localparam int IDX_W     = $clog2(FRAME_COUNT);
	localparam int WORD_W    = STAMP_BITS + vfs_pkg::BASE_W + PAGE_BITS;
	localparam int COIN_IX_W = $clog2(vfs_pkg::COIN_W);
	localparam int K_W       = COIN_IX_W + 1;
	localparam int PAD_W     = vfs_pkg::OUT_TDATA_W - vfs_pkg::OUT_USED_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_REPLY
	} state_t;

	state_t state_q;

	// input fields
	logic [vfs_pkg::FRAME_W-1:0] in_frame;
	logic                        in_mapped;
	logic                        in_prot;
	logic [vfs_pkg::BASE_W-1:0]  in_base;
	logic [vfs_pkg::PAGE_W-1:0]  in_page;
	logic [vfs_pkg::STAMP_W-1:0] in_stamp;
	logic [vfs_pkg::COIN_W-1:0]  in_coin;

	assign in_frame  = s_tdata[3:0];
	assign in_mapped = s_tdata[4];
	assign in_prot   = s_tdata[5];
	assign in_base   = s_tdata[9:6];
	assign in_page   = s_tdata[25:10];
	assign in_stamp  = s_tdata[57:26];
	assign in_coin   = s_tdata[73:58];

	logic s_fire;
	logic ld_fire;
	logic reply_fire;
	logic [IDX_W-1:0] ld_idx;

	assign s_tready   = (state_q == ST_IDLE);
	assign s_fire     = s_tvalid && s_tready;
	assign ld_fire    = s_fire && (s_tuser == vfs_pkg::ACT_LOAD)
		&& (32'(in_frame) < FRAME_COUNT);
	assign ld_idx     = IDX_W'(in_frame);
	assign reply_fire = (state_q == ST_REPLY) && (!m_tvalid || m_tready);

	// flags
	logic [FRAME_COUNT-1:0] mapped_q;
	logic [FRAME_COUNT-1:0] prot_q;

	// scan and accumulators
	logic                       policy_q;
	logic [IDX_W-1:0]           addr_q;
	logic [vfs_pkg::COIN_W-1:0] coin_q;
	logic                       v_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic                       prot_s1;
	logic                       map_s1;
	logic                       free_found_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic                       any_q;
	logic [IDX_W-1:0]           last_idx_q;
	logic [STAMP_BITS-1:0]      last_stamp_q;
	logic                       rnd_found_q;
	logic [IDX_W-1:0]           rnd_idx_q;
	logic [K_W-1:0]             k_q;
	logic                       min_found_q;
	logic [STAMP_BITS-1:0]      min_q;
	logic [IDX_W-1:0]           min_idx_q;
	logic [IDX_W-1:0]           pick_q;
	vfs_pkg::status_t           res_status_q;
	logic                       res_evict_q;

	// table RAM: {page, base, stamp}
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	logic [IDX_W-1:0] pick_c;
	logic             oom_c;

	assign ram_wdata = {PAGE_BITS'(in_page), in_base, STAMP_BITS'(in_stamp)};
	assign ram_re    = (state_q == ST_SCAN) || (state_q == ST_DECIDE);
	assign ram_raddr = (state_q == ST_SCAN) ? addr_q : pick_c;

	vfs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(FRAME_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ld_fire),
		.waddr(ld_idx),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	logic [STAMP_BITS-1:0]      stamp_s1;
	logic [vfs_pkg::BASE_W-1:0] rd_base;
	logic [PAGE_BITS-1:0]       rd_page;
	logic                       unprot_s1;
	logic                       coin_hit;
	logic                       lru_take;

	assign stamp_s1  = ram_rdata[STAMP_BITS-1:0];
	assign rd_base   = ram_rdata[STAMP_BITS +: vfs_pkg::BASE_W];
	assign rd_page   = ram_rdata[STAMP_BITS + vfs_pkg::BASE_W +: PAGE_BITS];
	assign unprot_s1 = v_s1 && !prot_s1;
	assign coin_hit  = (k_q < K_W'(vfs_pkg::COIN_W)) && coin_q[k_q[COIN_IX_W-1:0]];
	// shared comparator: one stamp against the running minimum each cycle
	assign lru_take  = !min_found_q || (stamp_s1 < min_q);

	always_comb begin
		pick_c = last_idx_q;
		oom_c  = 1'b0;
		if (free_found_q) begin
			pick_c = free_idx_q;
		end else if (!any_q) begin
			pick_c = '0;
			oom_c  = 1'b1;
		end else if (policy_q == vfs_pkg::POL_RANDOM) begin
			pick_c = rnd_found_q ? rnd_idx_q : last_idx_q;
		end else begin
			// tie: last unprotected frame wins if it holds the minimum
			pick_c = (last_stamp_q == min_q) ? last_idx_q : min_idx_q;
		end
	end

	logic [vfs_pkg::FRAME_W-1:0] out_victim;
	logic [vfs_pkg::BASE_W-1:0]  out_base;
	logic [vfs_pkg::PAGE_W-1:0]  out_page;

	assign out_victim = (res_status_q == vfs_pkg::STAT_CHOSEN)
		? vfs_pkg::FRAME_W'(pick_q) : '0;
	assign out_base   = res_evict_q ? rd_base : '0;
	assign out_page   = res_evict_q ? vfs_pkg::PAGE_W'(rd_page) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q <= '0;
			prot_q   <= '0;
		end else begin
			if (ld_fire) begin
				mapped_q[ld_idx] <= in_mapped;
				prot_q[ld_idx]   <= in_prot;
			end
			// unmap the evicted frame as its result goes out
			if (reply_fire && res_evict_q) begin
				mapped_q[pick_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			policy_q     <= vfs_pkg::POL_LRU;
			addr_q       <= '0;
			coin_q       <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			prot_s1      <= 1'b0;
			map_s1       <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			any_q        <= 1'b0;
			last_idx_q   <= '0;
			last_stamp_q <= '0;
			rnd_found_q  <= 1'b0;
			rnd_idx_q    <= '0;
			k_q          <= '0;
			min_found_q  <= 1'b0;
			min_q        <= '0;
			min_idx_q    <= '0;
			pick_q       <= '0;
			res_status_q <= vfs_pkg::STAT_LOAD;
			res_evict_q  <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= vfs_pkg::STAT_LOAD;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_data;
			end
			if (m_tvalid && m_tready && !reply_fire) begin
				m_tvalid <= 1'b0;
			end

			v_s1    <= (state_q == ST_SCAN);
			idx_s1  <= addr_q;
			prot_s1 <= prot_q[addr_q];
			map_s1  <= mapped_q[addr_q];

			if (unprot_s1) begin
				any_q        <= 1'b1;
				last_idx_q   <= idx_s1;
				last_stamp_q <= stamp_s1;
				if (!map_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				if (!rnd_found_q && coin_hit) begin
					rnd_found_q <= 1'b1;
					rnd_idx_q   <= idx_s1;
				end
				if (k_q < K_W'(vfs_pkg::COIN_W)) begin
					k_q <= k_q + K_W'(1);
				end
				if (lru_take) begin
					min_found_q <= 1'b1;
					min_q       <= stamp_s1;
					min_idx_q   <= idx_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						coin_q       <= in_coin;
						addr_q       <= '0;
						free_found_q <= 1'b0;
						any_q        <= 1'b0;
						rnd_found_q  <= 1'b0;
						k_q          <= '0;
						min_found_q  <= 1'b0;
						if (s_tuser == vfs_pkg::ACT_LOAD) begin
							res_status_q <= vfs_pkg::STAT_LOAD;
							res_evict_q  <= 1'b0;
							state_q      <= ST_REPLY;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == IDX_W'(FRAME_COUNT - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					pick_q       <= pick_c;
					res_status_q <= oom_c ? vfs_pkg::STAT_OOM : vfs_pkg::STAT_CHOSEN;
					// no free frame left means every unprotected frame is mapped
					res_evict_q  <= !free_found_q && !oom_c;
					state_q      <= ST_REPLY;
				end
				ST_REPLY: begin
					if (reply_fire) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= {{PAD_W{1'b0}}, out_page, out_base, res_evict_q, out_victim};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`VFS_ASSERT_NOW(a_oom_clean, m_tvalid && (m_tuser == vfs_pkg::STAT_OOM),
		m_tdata[vfs_pkg::OUT_USED_W-1:0] == '0, "out-of-memory result carries data")
	`VFS_ASSERT_NOW(a_free_has_any, (state_q == ST_DECIDE) && free_found_q, any_q,
		"free frame found without any unprotected frame")
	`VFS_ASSERT_NEXT(a_unmap, reply_fire && res_evict_q, !mapped_q[$past(pick_q)],
		"evicted frame still mapped")
	`VFS_ASSERT_NOW(a_evict_chosen, (state_q == ST_REPLY) && res_evict_q,
		res_status_q == vfs_pkg::STAT_CHOSEN, "eviction without a chosen victim")

endmodule

// ===== hdl/vfs_ram.sv =====
module vfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
